### rtl/avclp_pkg.sv
`default_nettype none
package avclp_pkg;

  // Default store depths
  localparam int SPS_BYTES_DEF = 32;
  localparam int PPS_BYTES_DEF = 16;

  // Unit header constants
  localparam logic [4:0] TYPE_MASK   = 5'h1f;
  localparam logic [4:0] IDR_TYPE    = 5'd5;
  localparam logic [7:0] SC_LAST     = 8'h01;
  localparam logic [7:0] SC_ZERO     = 8'h00;
  localparam logic [1:0] SC_LAST_IDX = 2'd3;

  // Request action codes
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_SPS    = 2'd1;
  localparam logic [1:0] ACT_PPS    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_FIRST  = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SC_SPS,
    ST_SPS,
    ST_SC_PPS,
    ST_PPS,
    ST_SC_UNIT,
    ST_DATA,
    ST_TRUNC
  } seq_state_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_SPS,
    SRC_PPS
  } out_src_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       restart;
    logic       last_of_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       truncated;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/avc_length_prefix_to_start_code_top.sv
// A request's first result passes the sequencer state register, then the output register.
// Throughput: one result per cycle from a single output sequencer, held by out_stall;
// a request holds the input until its last result, so prefix, load and in-unit bytes run at
// one per cycle. An IDR's first byte follows start-coded SPS and PPS, one read per byte.
// Reset: parse state, counts and sequencer cleared, length size set to four bytes;
// the SPS and PPS stores are not cleared and hold undefined data until loaded.
`default_nettype none
module avc_length_prefix_to_start_code_top
  import avclp_pkg::*;
#(
  parameter int SPS_BYTES = SPS_BYTES_DEF,
  parameter int PPS_BYTES = PPS_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data
);

  localparam int SAW = $clog2(SPS_BYTES);
  localparam int PAW = $clog2(PPS_BYTES);
  localparam int SCW = $clog2(SPS_BYTES + 1);
  localparam int PCW = $clog2(PPS_BYTES + 1);

  // Parameter set stores
  logic [7:0] sps_mem [SPS_BYTES];
  logic [7:0] pps_mem [PPS_BYTES];

  // Parse state
  logic           four_byte_r;
  phase_t         phase_r, phase_nxt;
  logic [1:0]     prefix_cnt_r, prefix_cnt_nxt;
  logic [31:0]    gather_r, gather_nxt;
  logic [31:0]    remain_r, remain_nxt;
  logic [SCW-1:0] sps_cnt_r, sps_cnt_nxt;
  logic [PCW-1:0] pps_cnt_r, pps_cnt_nxt;

  // Sequencer state and plan
  seq_state_t     st_r, st_nxt, plan_st;
  logic [1:0]     sc_idx_r, sc_idx_nxt;
  logic [SAW-1:0] sps_idx_r, sps_idx_nxt;
  logic [PAW-1:0] pps_idx_r, pps_idx_nxt;
  logic [7:0]     byte_r;
  logic           has_data_r, trunc_r;

  // Output stage
  logic           out_valid_r;
  out_src_t       out_src_r;
  logic [7:0]     out_const_r;
  logic           out_last_r, out_trunc_r;
  logic [7:0]     sps_rd_r, pps_rd_r;

  // Handshake and plan decode
  logic           out_free, accept, ready, fin;
  logic           plan_data, plan_trunc, unit_sc, idr;
  logic           sps_we, pps_we;
  logic [SAW-1:0] sps_wa;
  logic [PAW-1:0] pps_wa;
  logic [SCW-1:0] sps_base;
  logic [PCW-1:0] pps_base;
  logic [2:0]     got, need;
  logic [31:0]    shifted, remain_dec;
  out_src_t       emit_src;
  logic [7:0]     emit_const;
  logic           emit_trunc;

  assign out_free = !out_valid_r || !out_stall;

  // Final result of the current request
  always_comb begin
    case (st_r)
      ST_SC_UNIT: fin = (sc_idx_r == SC_LAST_IDX) && !has_data_r && !trunc_r;
      ST_DATA:    fin = !trunc_r;
      ST_TRUNC:   fin = 1'b1;
      default:    fin = 1'b0;
    endcase
  end

  assign ready    = (st_r == ST_IDLE) || (fin && out_free);
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // Parse the accepted request, update stores and build the emit plan
  always_comb begin
    phase_nxt      = phase_r;
    prefix_cnt_nxt = prefix_cnt_r;
    gather_nxt     = gather_r;
    remain_nxt     = remain_r;
    sps_cnt_nxt    = sps_cnt_r;
    pps_cnt_nxt    = pps_cnt_r;
    sps_we         = 1'b0;
    pps_we         = 1'b0;
    sps_base       = in_item.restart ? '0 : sps_cnt_r;
    pps_base       = in_item.restart ? '0 : pps_cnt_r;
    sps_wa         = sps_base[SAW-1:0];
    pps_wa         = pps_base[PAW-1:0];
    got            = {1'b0, prefix_cnt_r} + 3'd1;
    need           = four_byte_r ? 3'd4 : 3'd2;
    shifted        = {gather_r[23:0], in_item.data_byte};
    remain_dec     = remain_r - 32'd1;
    plan_data      = 1'b0;
    plan_trunc     = 1'b0;
    unit_sc        = 1'b0;
    idr            = 1'b0;
    plan_st        = ST_IDLE;
    if (accept) begin
      case (in_item.action)
        ACT_SPS: begin
          sps_cnt_nxt = sps_base;
          if (sps_base < SCW'(SPS_BYTES)) begin
            sps_we      = 1'b1;
            sps_cnt_nxt = sps_base + 1'b1;
          end
        end
        ACT_PPS: begin
          pps_cnt_nxt = pps_base;
          if (pps_base < PCW'(PPS_BYTES)) begin
            pps_we      = 1'b1;
            pps_cnt_nxt = pps_base + 1'b1;
          end
        end
        ACT_SAMPLE: begin
          case (phase_r)
            PH_PREFIX: begin
              if (got >= need) begin
                prefix_cnt_nxt = '0;
                gather_nxt     = '0;
                if (shifted == 32'd0) begin
                  unit_sc = 1'b1;
                end else begin
                  remain_nxt = shifted;
                  phase_nxt  = PH_FIRST;
                end
              end else begin
                prefix_cnt_nxt = got[1:0];
                gather_nxt     = shifted;
              end
            end
            PH_FIRST: begin
              unit_sc    = 1'b1;
              idr        = (in_item.data_byte[4:0] & TYPE_MASK) == IDR_TYPE;
              plan_data  = 1'b1;
              remain_nxt = remain_dec;
              phase_nxt  = (remain_dec == 32'd0) ? PH_PREFIX : PH_BODY;
            end
            default: begin
              plan_data  = 1'b1;
              remain_nxt = remain_dec;
              phase_nxt  = (remain_dec == 32'd0) ? PH_PREFIX : PH_BODY;
            end
          endcase
          // End of sample: flag an unfinished prefix or unit, then drop parse state
          if (in_item.last_of_sample) begin
            plan_trunc     = (phase_nxt != PH_PREFIX) || (prefix_cnt_nxt != 2'd0);
            phase_nxt      = PH_PREFIX;
            prefix_cnt_nxt = '0;
            gather_nxt     = '0;
            remain_nxt     = '0;
          end
          if (idr) begin
            plan_st = ST_SC_SPS;
          end else if (unit_sc) begin
            plan_st = ST_SC_UNIT;
          end else if (plan_data) begin
            plan_st = ST_DATA;
          end else if (plan_trunc) begin
            plan_st = ST_TRUNC;
          end else begin
            plan_st = ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    st_nxt      = st_r;
    sc_idx_nxt  = sc_idx_r;
    sps_idx_nxt = sps_idx_r;
    pps_idx_nxt = pps_idx_r;
    if (out_free) begin
      case (st_r)
        ST_SC_SPS: begin
          if (sc_idx_r == SC_LAST_IDX) begin
            sc_idx_nxt = '0;
            st_nxt     = (sps_cnt_r != '0) ? ST_SPS : ST_SC_PPS;
          end else begin
            sc_idx_nxt = sc_idx_r + 2'd1;
          end
        end
        ST_SPS: begin
          if (SCW'(sps_idx_r) + 1'b1 == sps_cnt_r) begin
            sps_idx_nxt = '0;
            st_nxt      = ST_SC_PPS;
          end else begin
            sps_idx_nxt = sps_idx_r + 1'b1;
          end
        end
        ST_SC_PPS: begin
          if (sc_idx_r == SC_LAST_IDX) begin
            sc_idx_nxt = '0;
            st_nxt     = (pps_cnt_r != '0) ? ST_PPS : ST_SC_UNIT;
          end else begin
            sc_idx_nxt = sc_idx_r + 2'd1;
          end
        end
        ST_PPS: begin
          if (PCW'(pps_idx_r) + 1'b1 == pps_cnt_r) begin
            pps_idx_nxt = '0;
            st_nxt      = ST_SC_UNIT;
          end else begin
            pps_idx_nxt = pps_idx_r + 1'b1;
          end
        end
        ST_SC_UNIT: begin
          if (sc_idx_r == SC_LAST_IDX) begin
            sc_idx_nxt = '0;
            if (has_data_r) begin
              st_nxt = ST_DATA;
            end else if (trunc_r) begin
              st_nxt = ST_TRUNC;
            end else begin
              st_nxt = ST_IDLE;
            end
          end else begin
            sc_idx_nxt = sc_idx_r + 2'd1;
          end
        end
        ST_DATA:  st_nxt = trunc_r ? ST_TRUNC : ST_IDLE;
        ST_TRUNC: st_nxt = ST_IDLE;
        default:  st_nxt = ST_IDLE;
      endcase
    end
    if (accept) begin
      st_nxt = plan_st;
    end
  end

  // Sequencer outputs
  always_comb begin
    emit_src   = SRC_CONST;
    emit_const = SC_ZERO;
    emit_trunc = 1'b0;
    case (st_r)
      ST_SC_SPS, ST_SC_PPS, ST_SC_UNIT: begin
        emit_const = (sc_idx_r == SC_LAST_IDX) ? SC_LAST : SC_ZERO;
      end
      ST_SPS:   emit_src   = SRC_SPS;
      ST_PPS:   emit_src   = SRC_PPS;
      ST_DATA:  emit_const = byte_r;
      ST_TRUNC: emit_trunc = 1'b1;
      default:  ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_byte_r  <= 1'b1;
      phase_r      <= PH_PREFIX;
      prefix_cnt_r <= '0;
      gather_r     <= '0;
      remain_r     <= '0;
      sps_cnt_r    <= '0;
      pps_cnt_r    <= '0;
      st_r         <= ST_IDLE;
      sc_idx_r     <= '0;
      sps_idx_r    <= '0;
      pps_idx_r    <= '0;
      has_data_r   <= 1'b0;
      trunc_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        four_byte_r <= cfg_wr_data;
      end
      phase_r      <= phase_nxt;
      prefix_cnt_r <= prefix_cnt_nxt;
      gather_r     <= gather_nxt;
      remain_r     <= remain_nxt;
      sps_cnt_r    <= sps_cnt_nxt;
      pps_cnt_r    <= pps_cnt_nxt;
      st_r         <= st_nxt;
      sc_idx_r     <= sc_idx_nxt;
      sps_idx_r    <= sps_idx_nxt;
      pps_idx_r    <= pps_idx_nxt;
      if (accept) begin
        has_data_r <= plan_data;
        trunc_r    <= plan_trunc;
      end
      if (out_free) begin
        out_valid_r <= (st_r != ST_IDLE);
      end
    end
  end

  // Hold the sample byte of the current request
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_item.data_byte;
    end
  end

  // Store writes on load requests
  always_ff @(posedge clk) begin
    if (sps_we) begin
      sps_mem[sps_wa] <= in_item.data_byte;
    end
    if (pps_we) begin
      pps_mem[pps_wa] <= in_item.data_byte;
    end
  end

  // Store reads and output payload, advance when the output is free
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (st_r == ST_SPS) begin
        sps_rd_r <= sps_mem[sps_idx_r];
      end
      if (st_r == ST_PPS) begin
        pps_rd_r <= pps_mem[pps_idx_r];
      end
      out_src_r   <= emit_src;
      out_const_r <= emit_const;
      out_last_r  <= fin;
      out_trunc_r <= emit_trunc;
    end
  end

  // Select the result byte
  always_comb begin
    case (out_src_r)
      SRC_SPS: out_item.out_byte = sps_rd_r;
      SRC_PPS: out_item.out_byte = pps_rd_r;
      default: out_item.out_byte = out_const_r;
    endcase
  end

  assign out_item.run_last  = out_last_r;
  assign out_item.truncated = out_trunc_r;
  assign out_valid          = out_valid_r;

endmodule
`default_nettype wire
